// ===== design/bpdm_pkg.sv =====
// ----------------------------------------------------------------------------
// bpdm_pkg: shared types and constants for the button press duration monitor
// Register indexes, request codes, reset values and the front-to-back word.
// ----------------------------------------------------------------------------
package bpdm_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int TICK_WIDTH_DEF  = 32;
	localparam int QUEUE_DEPTH     = 2;

	typedef enum logic [1:0] {
		REQ_SCAN   = 2'd0,
		REQ_ANIM   = 2'd1,
		REQ_REPORT = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		REG_SHORT_LIMIT   = 3'd0,
		REG_TICK_PERIOD   = 3'd1,
		REG_STREAK_WINDOW = 3'd2,
		REG_STREAK_TRIG   = 3'd3,
		REG_SHORT_BLINKS  = 3'd4,
		REG_LONG_BLINKS   = 3'd5,
		REG_CELEB_BLINKS  = 3'd6
	} reg_idx_t;

	localparam logic [15:0] SHORT_LIMIT_RST   = 16'd500;
	localparam logic [7:0]  TICK_PERIOD_RST   = 8'd15;
	localparam logic [15:0] STREAK_WINDOW_RST = 16'd67;
	localparam logic [7:0]  STREAK_TRIG_RST   = 8'd3;
	localparam logic [4:0]  SHORT_BLINKS_RST  = 5'd5;
	localparam logic [4:0]  LONG_BLINKS_RST   = 5'd10;
	localparam logic [4:0]  CELEB_BLINKS_RST  = 5'd4;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_OUT
	} bk_state_t;

	// configuration seen by the back end
	typedef struct packed {
		logic [15:0] short_limit;
		logic [7:0]  tick_period;
		logic [15:0] streak_window;
		logic [7:0]  streak_trig;
		logic [4:0]  short_blinks;
		logic [4:0]  long_blinks;
		logic [4:0]  celeb_blinks;
	} cfg_t;

	// classified word from front to back
	typedef struct packed {
		logic [1:0]  req;
		logic        level;
		logic [63:0] now_tick;
	} cmd_t;

	// result word
	typedef struct packed {
		logic        led_grn;
		logic        led_red;
		logic        led_ylw;
		logic        press_done;
		logic [31:0] press_duration_ms;
		logic        press_short;
		logic [31:0] rep_total;
		logic [31:0] rep_short;
		logic [31:0] rep_long;
		logic [31:0] rep_avg_ms;
		logic [15:0] rep_best_streak;
		logic        rep_empty;
	} res_t;

endpackage

// ===== design/bpdm_if.sv =====
// ----------------------------------------------------------------------------
// bpdm_in_if / bpdm_out_if: valid/ready channels
// Input words carry a request; output words carry one result.
// ----------------------------------------------------------------------------
interface bpdm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic        button_level;
	logic [31:0] now_tick;
	modport source (output valid, req_type, button_level, now_tick, input ready);
	modport sink (input valid, req_type, button_level, now_tick, output ready);
endinterface

interface bpdm_out_if;
	logic        valid;
	logic        ready;
	logic        led_grn;
	logic        led_red;
	logic        led_ylw;
	logic        press_done;
	logic [31:0] press_duration_ms;
	logic        press_short;
	logic [31:0] rep_total;
	logic [31:0] rep_short;
	logic [31:0] rep_long;
	logic [31:0] rep_avg_ms;
	logic [15:0] rep_best_streak;
	logic        rep_empty;
	modport source (output valid, led_grn, led_red, led_ylw, press_done,
		press_duration_ms, press_short, rep_total, rep_short, rep_long, rep_avg_ms,
		rep_best_streak, rep_empty, input ready);
	modport sink (input valid, led_grn, led_red, led_ylw, press_done,
		press_duration_ms, press_short, rep_total, rep_short, rep_long, rep_avg_ms,
		rep_best_streak, rep_empty, output ready);
endinterface

// ===== design/button_press_duration_monitor.sv =====
// Scan, animation and unknown words pass the queue and are registered in the
// output register; report words with a nonzero total also wait for the divider.
// Throughput: one word per cycle through the queue while the output is free;
// the back end takes no new word while the divider runs, but the queue fills.
// Reset: arst_n clears control state and counters and loads register defaults.
// ----------------------------------------------------------------------------
// button_press_duration_monitor: top level
// Configuration registers, input queue front end and executing back end.
// ----------------------------------------------------------------------------
module button_press_duration_monitor
	import bpdm_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int TICK_WIDTH  = TICK_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bpdm_in_if.sink     in_ch,
	bpdm_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_wdata
);
	cfg_t cfg_q;
	logic cmd_valid, cmd_pop;
	cmd_t cmd;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_limit   <= SHORT_LIMIT_RST;
			cfg_q.tick_period   <= TICK_PERIOD_RST;
			cfg_q.streak_window <= STREAK_WINDOW_RST;
			cfg_q.streak_trig   <= STREAK_TRIG_RST;
			cfg_q.short_blinks  <= SHORT_BLINKS_RST;
			cfg_q.long_blinks   <= LONG_BLINKS_RST;
			cfg_q.celeb_blinks  <= CELEB_BLINKS_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SHORT_LIMIT:   cfg_q.short_limit   <= cfg_wdata;
				REG_TICK_PERIOD:   cfg_q.tick_period   <= cfg_wdata[7:0];
				REG_STREAK_WINDOW: cfg_q.streak_window <= cfg_wdata;
				REG_STREAK_TRIG:   cfg_q.streak_trig   <= cfg_wdata[7:0];
				REG_SHORT_BLINKS:  cfg_q.short_blinks  <= cfg_wdata[4:0];
				REG_LONG_BLINKS:   cfg_q.long_blinks   <= cfg_wdata[4:0];
				REG_CELEB_BLINKS:  cfg_q.celeb_blinks  <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	bpdm_front #(.TICK_WIDTH(TICK_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd)
	);

	bpdm_back #(.COUNT_WIDTH(COUNT_WIDTH), .TICK_WIDTH(TICK_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd), .out_ch(out_ch)
	);
endmodule

// ===== design/bpdm_front.sv =====
// ----------------------------------------------------------------------------
// bpdm_front: input acceptance and command queue
// Takes input words, masks the tick and queues them for the back end.
// ----------------------------------------------------------------------------
module bpdm_front
	import bpdm_pkg::*;
#(
	parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	bpdm_in_if.sink in_ch,
	output logic cmd_valid,
	input  logic cmd_pop,
	output cmd_t cmd
);
	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t            mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     cnt_q;
	logic            push;
	cmd_t            in_cmd;

	assign in_ch.ready = (cnt_q != QUEUE_DEPTH[PW:0]);
	assign push        = in_ch.valid && in_ch.ready;
	assign cmd_valid   = (cnt_q != '0);
	assign cmd         = mem_q[rd_q];

	// tick limited to the tick width
	always_comb begin
		in_cmd          = '0;
		in_cmd.req      = in_ch.req_type;
		in_cmd.level    = in_ch.button_level;
		in_cmd.now_tick = 64'(in_ch.now_tick);
		if (TICK_WIDTH < 64)
			in_cmd.now_tick = in_cmd.now_tick & ((64'd1 << TICK_WIDTH) - 64'd1);
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= PW'((32'(wr_q) + 1) % QUEUE_DEPTH);
			if (cmd_pop)
				rd_q <= PW'((32'(rd_q) + 1) % QUEUE_DEPTH);
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(cmd_pop);
		end
	end
endmodule

// ===== design/bpdm_div.sv =====
// ----------------------------------------------------------------------------
// bpdm_div: serial restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module bpdm_div
	import bpdm_pkg::*;
#(
	parameter int WIDTH = COUNT_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             done,
	output logic [WIDTH-1:0] quotient
);
	localparam int CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] quo_q, den_q;
	logic [WIDTH:0]   rem_q, trial;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;

	assign trial    = {rem_q[WIDTH-1:0], quo_q[WIDTH-1]} - {1'b0, den_q};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[WIDTH]) begin
				rem_q <= trial;
				quo_q <= {quo_q[WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[WIDTH-1:0], quo_q[WIDTH-1]};
				quo_q <= {quo_q[WIDTH-2:0], 1'b0};
			end
		end
	end
endmodule

// ===== design/bpdm_back.sv =====
// ----------------------------------------------------------------------------
// bpdm_back: press tracking, statistics, blink sequencing and reporting
// Executes one queued command, holds the result in an output register.
// ----------------------------------------------------------------------------
module bpdm_back
	import bpdm_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int TICK_WIDTH  = TICK_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic cmd_valid,
	output logic cmd_pop,
	input  cmd_t cmd,
	bpdm_out_if.source out_ch
);
	localparam int CW = COUNT_WIDTH;
	localparam int TW = TICK_WIDTH;

	bk_state_t state_q, state_d;

	logic          was_held_q, ev_pend_q, ev_short_q, phase_q, celeb_q;
	logic [TW-1:0] press_start_q, last_press_q;
	logic [31:0]   ev_dur_q;
	logic [CW-1:0] tot_q, shrt_q, lng_q, sum_q;
	logic [15:0]   streak_q, best_q;
	logic [5:0]    blink_q;
	logic [2:0]    led_q;
	res_t          res_q;

	// divider for the report average
	logic          div_start, div_done;
	logic [CW-1:0] div_quo;
	bpdm_div #(.WIDTH(CW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(sum_q), .divisor(tot_q), .done(div_done), .quotient(div_quo)
	);

	logic          take, out_free;
	logic [TW-1:0] now, dt, gap;
	logic [TW+7:0] dur_full;
	logic [31:0]   dur;
	logic          is_short;

	assign out_free = !out_ch.valid || out_ch.ready;
	assign now      = cmd.now_tick[TW-1:0];
	assign dt       = now - press_start_q;
	assign gap      = now - last_press_q;
	assign dur_full = dt * cfg.tick_period;
	assign dur      = 32'(dur_full);
	assign is_short = dur < 32'(cfg.short_limit);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid && out_free) begin
					if (cmd.req == REQ_REPORT && tot_q != '0)
						state_d = BK_DIV;
				end
			end
			BK_DIV:  if (div_done) state_d = BK_OUT;
			BK_OUT:  if (out_free) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		take      = 1'b0;
		div_start = 1'b0;
		case (state_q)
			BK_IDLE: begin
				take      = cmd_valid && out_free &&
					!(cmd.req == REQ_REPORT && tot_q != '0);
				div_start = cmd_valid && out_free && cmd.req == REQ_REPORT &&
					tot_q != '0;
			end
			BK_OUT:  take = out_free;
			default: ;
		endcase
	end
	assign cmd_pop = take;

	assign out_ch.led_grn           = res_q.led_grn;
	assign out_ch.led_red           = res_q.led_red;
	assign out_ch.led_ylw           = res_q.led_ylw;
	assign out_ch.press_done        = res_q.press_done;
	assign out_ch.press_duration_ms = res_q.press_duration_ms;
	assign out_ch.press_short       = res_q.press_short;
	assign out_ch.rep_total         = res_q.rep_total;
	assign out_ch.rep_short         = res_q.rep_short;
	assign out_ch.rep_long          = res_q.rep_long;
	assign out_ch.rep_avg_ms        = res_q.rep_avg_ms;
	assign out_ch.rep_best_streak   = res_q.rep_best_streak;
	assign out_ch.rep_empty         = res_q.rep_empty;

	// command execution
	always_ff @(posedge clk or negedge arst_n) begin
		logic [2:0]  led;
		logic [15:0] stk;
		logic        cel, ph;
		logic [5:0]  bl;
		res_t        r;
		if (!arst_n) begin
			state_q       <= BK_IDLE;
			out_ch.valid  <= 1'b0;
			was_held_q    <= 1'b0;
			ev_pend_q     <= 1'b0;
			ev_short_q    <= 1'b0;
			phase_q       <= 1'b0;
			celeb_q       <= 1'b0;
			press_start_q <= '0;
			last_press_q  <= '0;
			ev_dur_q      <= '0;
			tot_q         <= '0;
			shrt_q        <= '0;
			lng_q         <= '0;
			sum_q         <= '0;
			streak_q      <= '0;
			best_q        <= '0;
			blink_q       <= '0;
			led_q         <= '0;
			res_q         <= '0;
		end else begin
			state_q <= state_d;
			if (take) begin
				led = led_q;
				stk = streak_q;
				cel = celeb_q;
				ph  = phase_q;
				bl  = blink_q;
				r   = '0;
				case (cmd.req)
					REQ_SCAN: begin
						if (cmd.level && !was_held_q) begin
							press_start_q <= now;
							led[1:0] = 2'b00;
						end
						if (!cmd.level && was_held_q) begin
							ev_dur_q   <= dur;
							ev_short_q <= is_short;
							ev_pend_q  <= 1'b1;
							led[1:0]   = is_short ? 2'b01 : 2'b10;
							r.press_done        = 1'b1;
							r.press_duration_ms = dur;
							r.press_short       = is_short;
						end
						was_held_q <= cmd.level;
					end
					REQ_ANIM: begin
						if (ev_pend_q) begin
							tot_q <= tot_q + 1'b1;
							sum_q <= sum_q + CW'(ev_dur_q);
							if (ev_short_q)
								shrt_q <= shrt_q + 1'b1;
							else
								lng_q <= lng_q + 1'b1;
							if (last_press_q != '0 && gap < TW'(cfg.streak_window)) begin
								if (stk != 16'hFFFF)
									stk = stk + 1'b1;
							end else begin
								stk = 16'd1;
							end
							last_press_q <= now;
							if (stk > best_q)
								best_q <= stk;
							if (stk >= 16'(cfg.streak_trig))
								cel = 1'b1;
							if (cel)
								bl = {cfg.celeb_blinks, 1'b0};
							else if (ev_short_q)
								bl = {cfg.short_blinks, 1'b0};
							else
								bl = {cfg.long_blinks, 1'b0};
							ph = 1'b0;
							ev_pend_q <= 1'b0;
						end
						// one blink half-cycle
						if (bl != '0) begin
							ph = !ph;
							if (cel)
								led = ph ? 3'b111 : 3'b000;
							else
								led[2] = ph;
							bl = bl - 1'b1;
							if (bl == '0) begin
								if (cel)
									led[1:0] = 2'b00;
								cel = 1'b0;
							end
						end else begin
							led[2] = 1'b0;
						end
					end
					REQ_REPORT: begin
						r.rep_total       = 32'(tot_q);
						r.rep_short       = 32'(shrt_q);
						r.rep_long        = 32'(lng_q);
						r.rep_avg_ms      = (tot_q != '0) ? 32'(div_quo) : 32'd0;
						r.rep_best_streak = best_q;
						r.rep_empty       = (tot_q == '0);
						tot_q  <= '0;
						shrt_q <= '0;
						lng_q  <= '0;
						sum_q  <= '0;
						best_q <= '0;
					end
					default: ;
				endcase
				streak_q <= stk;
				celeb_q  <= cel;
				phase_q  <= ph;
				blink_q  <= bl;
				led_q    <= led;
				r.led_grn    = led[0];
				r.led_red    = led[1];
				r.led_ylw    = led[2];
				res_q        <= r;
				out_ch.valid <= 1'b1;
			end else if (out_ch.ready) begin
				out_ch.valid <= 1'b0;
			end
		end
	end
endmodule
